/* rtl/kme_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kme_pkg
// Shared constants, types and helpers of the k-mer minimizer extractor.
// ----------------------------------------------------------------------------
package kme_pkg;

  localparam int KMER_W     = 62;
  localparam int POS_W      = 16;
  localparam int CFG_W      = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int DEPTH      = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int HRND_W     = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_KMER_LENGTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 1'b1;

  localparam logic [CFG_W-1:0] KMER_LENGTH_RST = 5'd15;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 5'd10;

  localparam logic [HRND_W-1:0] HASH_LAST = 2'd3;

  typedef logic [KMER_W-1:0] kmer_t;

  typedef struct packed {
    logic load;
    logic hash;
    logic head_pop;
    logic tail_pop;
    logic push;
    logic emit;
    logic emit_back;
    logic emit_fin;
    logic clear;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic cnt_nz;
    logic front_old;
    logic back_pop;
    logic back_min;
    logic full;
    logic front_min;
    logic complete;
    logic read_end;
    logic hash_done;
    logic emit_ok;
    logic flush_ok;
  } sts_t;

  // Low 2k bits set
  function automatic kmer_t kmer_mask(input logic [CFG_W-1:0] k);
    kmer_t m;
    for (int i = 0; i < KMER_W; i++) begin
      m[i] = (i < 2 * int'(k));
    end
    return m;
  endfunction

endpackage

/* rtl/kme_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kme_ctrl
// Per-base sequencer: hash, front expiry, back pops, full-deque pop, push, end of read, flush.
// ----------------------------------------------------------------------------
module kme_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  kme_pkg::sts_t sts,
  output kme_pkg::cmd_t cmd
);
  import kme_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_HASH   = 8'b0000_0010,
    ST_FRONT  = 8'b0000_0100,
    ST_BACK   = 8'b0000_1000,
    ST_FULL   = 8'b0001_0000,
    ST_PUSH   = 8'b0010_0000,
    ST_FINISH = 8'b0100_0000,
    ST_FLUSH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd.hash = 1'b1;
        if (sts.hash_done) begin
          state_nxt = sts.complete ? ST_FRONT : ST_FINISH;
        end
      end
      ST_FRONT: begin
        if (sts.front_old) begin
          if (sts.emit_ok) begin
            cmd.head_pop = 1'b1;
            cmd.emit     = 1'b1;
            state_nxt    = ST_BACK;
          end
        end else begin
          state_nxt = ST_BACK;
        end
      end
      ST_BACK: begin
        if (sts.back_pop) begin
          if (sts.back_min) begin
            if (sts.emit_ok) begin
              cmd.tail_pop  = 1'b1;
              cmd.emit      = 1'b1;
              cmd.emit_back = 1'b1;
            end
          end else begin
            cmd.tail_pop = 1'b1;
          end
        end else begin
          state_nxt = ST_FULL;
        end
      end
      ST_FULL: begin
        if (sts.full) begin
          if (sts.front_min) begin
            if (sts.emit_ok) begin
              cmd.head_pop = 1'b1;
              cmd.emit     = 1'b1;
              state_nxt    = ST_PUSH;
            end
          end else begin
            cmd.head_pop = 1'b1;
            state_nxt    = ST_PUSH;
          end
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.read_end) begin
          if (sts.cnt_nz) begin
            if (sts.emit_ok) begin
              cmd.emit     = 1'b1;
              cmd.emit_fin = 1'b1;
              cmd.clear    = 1'b1;
              state_nxt    = ST_FLUSH;
            end
          end else begin
            cmd.clear = 1'b1;
            state_nxt = ST_FLUSH;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/kme_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kme_datapath
// Rolling k-mer, iterative hash, shift-register deque and output staging.
// ----------------------------------------------------------------------------
module kme_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [kme_pkg::CFG_W-1:0]   k_eff,
  input  logic [kme_pkg::CFG_W-1:0]   w_eff,
  input  logic [1:0]                  base_code,
  input  logic                        read_end,
  input  kme_pkg::cmd_t               cmd,
  output kme_pkg::sts_t               sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [kme_pkg::KMER_W-1:0]  out_seed,
  output logic                        out_last,
  output logic                        out_fin
);
  import kme_pkg::*;

  // deque: entry 0 is the newest (back), entry count-1 the oldest (front)
  kmer_t              seed_r [DEPTH];
  kmer_t              hash_r [DEPTH];
  logic [POS_W-1:0]   epos_r [DEPTH];
  logic [DEPTH-1:0]   wmin_r;
  logic [CNT_W-1:0]   count_r;
  logic               steady_r;

  kmer_t              rolling_r;
  logic [POS_W-1:0]   base_pos_r;
  logic [POS_W-1:0]   item_pos_r;
  logic               complete_r;
  logic               read_end_r;
  kmer_t              hv_r;
  logic [HRND_W-1:0]  hround_r;

  logic               pend_vld_r;
  kmer_t              pend_seed_r;
  logic               pend_fin_r;
  logic               out_vld_r;
  kmer_t              out_seed_r;
  logic               out_last_r;
  logic               out_fin_r;

  kmer_t              mask;
  kmer_t              rolling_nxt;
  kmer_t              hv_nxt;
  kmer_t              hadd;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   front_idx;
  logic [POS_W-1:0]   age;
  logic               cnt_nz;
  logic               complete_nxt;
  logic               steady_nxt;
  logic               out_free;
  kmer_t              emit_seed;

  assign mask        = kmer_mask(k_eff);
  assign rolling_nxt = {rolling_r[KMER_W-3:0], base_code} & mask;
  assign cnt_nz      = (count_r != '0);
  assign cnt_m1      = count_r - CNT_W'(1);
  assign front_idx   = cnt_m1[IDX_W-1:0];
  assign age         = item_pos_r - epos_r[front_idx];

  assign complete_nxt = steady_r || cnt_nz ||
                        ({1'b0, base_pos_r} + 17'd1 >= {12'd0, k_eff});
  assign steady_nxt   = steady_r ||
                        ({1'b0, item_pos_r} + 17'd2 >= {12'd0, k_eff} + {12'd0, w_eff});

  always_comb begin
    hadd   = '0;
    hv_nxt = hv_r;
    case (hround_r)
      2'd0: begin
        hadd   = (~hv_r + (hv_r << 21)) & mask;
        hv_nxt = hadd ^ (hadd >> 24);
      end
      2'd1: begin
        hadd   = (hv_r + (hv_r << 3) + (hv_r << 8)) & mask;
        hv_nxt = hadd ^ (hadd >> 14);
      end
      2'd2: begin
        hadd   = (hv_r + (hv_r << 2) + (hv_r << 4)) & mask;
        hv_nxt = hadd ^ (hadd >> 28);
      end
      2'd3: begin
        hadd   = (hv_r + (hv_r << 31)) & mask;
        hv_nxt = hadd;
      end
      default: begin
        hadd   = '0;
        hv_nxt = hv_r;
      end
    endcase
  end

  assign out_free  = !out_vld_r || out_tready;
  assign emit_seed = cmd.emit_back ? seed_r[0] : seed_r[front_idx];

  always_comb begin
    sts           = '0;
    sts.cnt_nz    = cnt_nz;
    sts.front_old = cnt_nz && (age >= {11'd0, w_eff});
    sts.back_pop  = cnt_nz && (hash_r[0] >= hv_r);
    sts.back_min  = wmin_r[0];
    sts.full      = (count_r == CNT_W'(DEPTH));
    sts.front_min = wmin_r[front_idx];
    sts.complete  = complete_r;
    sts.read_end  = read_end_r;
    sts.hash_done = (hround_r == HASH_LAST);
    sts.emit_ok   = !pend_vld_r || out_free;
    sts.flush_ok  = !pend_vld_r || out_free;
  end

  // control and reset-valued state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rolling_r  <= '0;
      base_pos_r <= '0;
      count_r    <= '0;
      steady_r   <= 1'b0;
      hround_r   <= '0;
      complete_r <= 1'b0;
      read_end_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        rolling_r  <= rolling_nxt;
        base_pos_r <= base_pos_r + POS_W'(1);
        complete_r <= complete_nxt;
        read_end_r <= read_end;
        hround_r   <= '0;
      end
      if (cmd.hash) begin
        hround_r <= hround_r + HRND_W'(1);
      end
      if (cmd.head_pop || cmd.tail_pop) begin
        count_r <= cnt_m1;
      end
      if (cmd.push) begin
        count_r  <= count_r + CNT_W'(1);
        steady_r <= steady_nxt;
      end
      if (cmd.clear) begin
        rolling_r  <= '0;
        base_pos_r <= '0;
        count_r    <= '0;
        steady_r   <= 1'b0;
      end
      if (cmd.emit) begin
        if (pend_vld_r) begin
          out_vld_r <= 1'b1;
        end else if (out_tready) begin
          out_vld_r <= 1'b0;
        end
        pend_vld_r <= 1'b1;
      end else if (cmd.flush && pend_vld_r) begin
        out_vld_r  <= 1'b1;
        pend_vld_r <= 1'b0;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_pos_r <= base_pos_r;
      hv_r       <= rolling_nxt;
    end
    if (cmd.hash) begin
      hv_r <= hv_nxt;
    end
    if (cmd.tail_pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        seed_r[i] <= seed_r[i+1];
        hash_r[i] <= hash_r[i+1];
        epos_r[i] <= epos_r[i+1];
        wmin_r[i] <= wmin_r[i+1];
      end
    end
    if (cmd.push) begin
      seed_r[0] <= rolling_r;
      hash_r[0] <= hv_r;
      epos_r[0] <= item_pos_r;
      // front after the push sits at the old count
      wmin_r[0] <= steady_nxt && (count_r[IDX_W-1:0] == '0);
      for (int i = 1; i < DEPTH; i++) begin
        seed_r[i] <= seed_r[i-1];
        hash_r[i] <= hash_r[i-1];
        epos_r[i] <= epos_r[i-1];
        wmin_r[i] <= wmin_r[i-1] ||
                     (steady_nxt && (count_r[IDX_W-1:0] == IDX_W'(i)));
      end
    end
    if (cmd.emit) begin
      if (pend_vld_r) begin
        out_seed_r <= pend_seed_r;
        out_fin_r  <= pend_fin_r;
        out_last_r <= 1'b0;
      end
      pend_seed_r <= emit_seed;
      pend_fin_r  <= cmd.emit_fin;
    end else if (cmd.flush && pend_vld_r) begin
      out_seed_r <= pend_seed_r;
      out_fin_r  <= pend_fin_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_seed   = out_seed_r;
  assign out_last   = out_last_r;
  assign out_fin    = out_fin_r;

endmodule

/* rtl/kmer_minimizer_extractor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_minimizer_extractor
// Sliding-window minimizer seeds of a DNA read, one base per request.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata[1:0] base_code, tlast read_end
//  out_    | master    | tdata[61:0] minimizer_seed, tlast last_in_run,
//          |           | tuser read_final
//  cfg_    | write     | addr 0 kmer_length, addr 1 window_size
//
// A base runs through load, a four-round hash, front expiry, one back pop
// per back entry dropped, full check, push, end of read and flush; a base
// that completes no k-mer goes from the hash to end of read. Results pass
// through a one-deep hold and an output register; a held output stalls the
// sequencer at its next emit or at the end-of-base flush.
// Reset is synchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module kmer_minimizer_extractor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [1:0] base_code
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,  // [61:0] minimizer_seed
  output logic                            out_tlast,
  output logic                            out_tuser,  // [0] read_final
  input  logic                            cfg_we,
  input  logic [kme_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [kme_pkg::CFG_W-1:0]       cfg_wdata
);
  import kme_pkg::*;

  logic [CFG_W-1:0] kmer_length_r;
  logic [CFG_W-1:0] window_size_r;
  logic [CFG_W-1:0] k_eff;
  logic [CFG_W-1:0] w_eff;
  cmd_t             cmd;
  sts_t             sts;
  kmer_t            out_seed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= KMER_LENGTH_RST;
      window_size_r <= WINDOW_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KMER_LENGTH: kmer_length_r <= cfg_wdata;
        REG_WINDOW_SIZE: window_size_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign k_eff = (kmer_length_r == '0) ? CFG_W'(1) : kmer_length_r;
  assign w_eff = (window_size_r == '0)         ? CFG_W'(1) :
                 (window_size_r > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : window_size_r;

  kme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kme_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .k_eff      (k_eff),
    .w_eff      (w_eff),
    .base_code  (in_tdata[1:0]),
    .read_end   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_seed   (out_seed),
    .out_last   (out_tlast),
    .out_fin    (out_tuser)
  );

  assign out_tdata = {2'b00, out_seed};

endmodule

/* sim/kmer_minimizer_extractor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_minimizer_extractor_tb
// Drives reads of 2-bit bases into the minimizer extractor and checks every
// emitted seed against an in-bench prediction of the rolling k-mer, the hash
// and the monotone deque. Covers register extremes, short reads, mid-read
// register changes, ties, random stalls on both sides, a long output hold
// that backs up the input, and a final stretch with no idling.
// ----------------------------------------------------------------------------

typedef struct {
  logic [61:0] seed;
  logic        last;
  logic        fin;
} seed_result_t;

class minimizer_scoreboard;
  logic [4:0]   kmer_len_reg;
  logic [4:0]   window_reg;
  logic [61:0]  kmer_roll;
  logic [15:0]  read_pos;
  logic [61:0]  dq_seed [16];
  logic [63:0]  dq_hash [16];
  logic [15:0]  dq_end  [16];
  bit           dq_min  [16];
  int           dq_head;
  int           dq_cnt;
  bit           steady;
  seed_result_t run_seeds[$];
  seed_result_t expected_seeds[$];
  int           errors;

  function new();
    kmer_len_reg = kme_pkg::KMER_LENGTH_RST;
    window_reg   = kme_pkg::WINDOW_SIZE_RST;
    errors       = 0;
    clear_read();
  endfunction

  function void clear_read();
    kmer_roll = '0;
    read_pos  = '0;
    for (int i = 0; i < 16; i++) begin
      dq_seed[i] = '0;
      dq_hash[i] = '0;
      dq_end[i]  = '0;
      dq_min[i]  = 1'b0;
    end
    dq_head = 0;
    dq_cnt  = 0;
    steady  = 1'b0;
  endfunction

  function void write_reg(logic [kme_pkg::CFG_ADDR_W-1:0] addr, logic [4:0] val);
    if (addr == kme_pkg::REG_KMER_LENGTH) kmer_len_reg = val;
    else if (addr == kme_pkg::REG_WINDOW_SIZE) window_reg = val;
  endfunction

  function logic [63:0] seed_hash(logic [63:0] v, logic [63:0] m);
    v = (~v + (v << 21)) & m;
    v = v ^ (v >> 24);
    v = (v + (v << 3) + (v << 8)) & m;
    v = v ^ (v >> 14);
    v = (v + (v << 2) + (v << 4)) & m;
    v = v ^ (v >> 28);
    v = (v + (v << 31)) & m;
    return v;
  endfunction

  function void emit_seed(logic [61:0] s, bit fin);
    seed_result_t r;
    r.seed = s;
    r.last = 1'b0;
    r.fin  = fin;
    run_seeds = {run_seeds, r};
  endfunction

  function void pop_oldest();
    dq_head = (dq_head + 1) % 16;
    dq_cnt--;
  endfunction

  // Accepted base: advance the prediction and queue the seeds it releases
  function void note_base(logic [1:0] base, bit read_end);
    int          k;
    int          w;
    int          pos;
    int          b;
    int          slot;
    logic [63:0] mask;
    logic [63:0] h;
    logic [63:0] roll;
    logic [15:0] age;
    seed_result_t r;

    run_seeds.delete();
    k = (kmer_len_reg == 0) ? 1 : int'(kmer_len_reg);
    w = (window_reg == 0) ? 1 : (window_reg > 16) ? 16 : int'(window_reg);
    pos  = int'(read_pos);
    mask = (64'd1 << (2 * k)) - 64'd1;
    roll = (({2'b00, kmer_roll} << 2) | {62'd0, base}) & mask;
    kmer_roll = roll[61:0];

    if (steady || dq_cnt > 0 || pos + 1 >= k) begin
      h = seed_hash(roll, mask);
      if (dq_cnt > 0) begin
        age = read_pos - dq_end[dq_head];
        if (age >= w) begin
          emit_seed(dq_seed[dq_head], 1'b0);
          pop_oldest();
        end
      end
      while (dq_cnt > 0) begin
        b = (dq_head + dq_cnt - 1) % 16;
        if (dq_hash[b] < h) break;
        if (dq_min[b]) emit_seed(dq_seed[b], 1'b0);
        dq_cnt--;
      end
      if (dq_cnt >= 16) begin
        if (dq_min[dq_head]) emit_seed(dq_seed[dq_head], 1'b0);
        pop_oldest();
      end
      slot = (dq_head + dq_cnt) % 16;
      dq_seed[slot] = kmer_roll;
      dq_hash[slot] = h;
      dq_end[slot]  = read_pos;
      dq_min[slot]  = 1'b0;
      dq_cnt++;
      if (!steady && pos + 2 >= k + w) steady = 1'b1;
      if (steady) dq_min[dq_head] = 1'b1;
    end
    read_pos = read_pos + 16'd1;

    if (read_end) begin
      if (dq_cnt > 0) emit_seed(dq_seed[dq_head], 1'b1);
      clear_read();
    end

    foreach (run_seeds[i]) begin
      r = run_seeds[i];
      r.last = (i == run_seeds.size() - 1);
      expected_seeds = {expected_seeds, r};
    end
  endfunction

  function void check_seed(logic [61:0] seed, logic last, logic fin);
    seed_result_t e;
    if (expected_seeds.size() == 0) begin
      $error("unexpected result: minimizer_seed %h last_in_run %b read_final %b",
             seed, last, fin);
      errors++;
      return;
    end
    e = expected_seeds[0];
    expected_seeds.delete(0);
    if (seed !== e.seed) begin
      $error("minimizer_seed expected %h actual %h", e.seed, seed);
      errors++;
    end
    if (last !== e.last) begin
      $error("last_in_run expected %b actual %b", e.last, last);
      errors++;
    end
    if (fin !== e.fin) begin
      $error("read_final expected %b actual %b", e.fin, fin);
      errors++;
    end
  endfunction

  function int pending();
    return expected_seeds.size();
  endfunction
endclass

module kmer_minimizer_extractor_tb;

  localparam int SETTLE     = 48;
  localparam int LONG_STALL = 400;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [63:0]                    out_tdata;
  logic                           out_tlast;
  logic                           out_tuser;
  logic                           cfg_we;
  logic [kme_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [kme_pkg::CFG_W-1:0]      cfg_wdata;

  minimizer_scoreboard sb;
  int bases_sent;
  bit gaps_on;
  bit quiet;
  bit stall_req;
  bit stall_taken;
  int k_sel;
  int w_sel;
  int phase_items;
  int read_len;
  bit open_read;
  int random_goal;

  kmer_minimizer_extractor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic send_base(input logic [1:0] b, input bit last);
    in_tdata  <= {6'd0, b};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_base(b, last);
    bases_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // runs: bias toward repeated bases so equal hashes show up
  task automatic send_bases(input int count, input bit close_read, input bit runs);
    logic [1:0] b;
    b = 2'($urandom_range(0, 3));
    for (int i = 0; i < count; i++) begin
      if (!runs || $urandom_range(0, 2) == 0) b = 2'($urandom_range(0, 3));
      send_base(b, close_read && (i == count - 1));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kme_pkg::CFG_ADDR_W-1:0] a, input int v);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= 5'(v);
    @(posedge clk);
    sb.write_reg(a, 5'(v));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cfg(input int k, input int w);
    drain();
    write_reg(kme_pkg::REG_KMER_LENGTH, k);
    write_reg(kme_pkg::REG_WINDOW_SIZE, w);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_seed(out_tdata[61:0], out_tlast, out_tuser);
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb          = new();
    bases_sent  = 0;
    gaps_on     = 1'b1;
    quiet       = 1'b0;
    stall_taken = 1'b0;
    stall_req   <= 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_addr    <= '0;
    cfg_wdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest k-mer and window, every base code
    set_cfg(1, 1);
    send_base(2'd3, 1'b0);
    send_base(2'd2, 1'b0);
    send_base(2'd1, 1'b0);
    send_base(2'd0, 1'b1);
    // longest k-mer, read too short to complete one
    set_cfg(31, 16);
    send_bases(3, 1'b1, 1'b0);
    // window shrinks mid-read, then length changes mid-read
    set_cfg(2, 16);
    send_bases(6, 1'b0, 1'b0);
    drain();
    write_reg(kme_pkg::REG_WINDOW_SIZE, 2);
    send_bases(3, 1'b0, 1'b0);
    set_cfg(0, 0);
    send_bases(3, 1'b1, 1'b0);
    // window above range, read ends before one full window
    set_cfg(3, 20);
    send_bases(4, 1'b1, 1'b0);
    // equal hashes drop the older entry
    set_cfg(1, 31);
    send_base(2'd0, 1'b0);
    send_base(2'd0, 1'b0);
    send_base(2'd0, 1'b1);

    random_goal = bases_sent + 200;
    k_sel = kme_pkg::KMER_LENGTH_RST;
    w_sel = kme_pkg::WINDOW_SIZE_RST;
    while (bases_sent < random_goal) begin
      set_cfg(k_sel, w_sel);
      phase_items = 0;
      while (phase_items < 30) begin
        if ($urandom_range(0, 3) == 0) read_len = $urandom_range(1, k_sel + 1);
        else read_len = $urandom_range(1, k_sel + w_sel + 12);
        open_read = (phase_items + read_len >= 30) && ($urandom_range(0, 2) == 0);
        send_bases(read_len, !open_read, $urandom_range(0, 2) == 0);
        phase_items += read_len;
      end
      case ($urandom_range(0, 5))
        0:       k_sel = 0;
        1:       k_sel = 31;
        2:       k_sel = $urandom_range(0, 31);
        default: k_sel = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 4))
        0:       w_sel = 1;
        1:       w_sel = 16;
        2:       w_sel = $urandom_range(17, 31);
        default: w_sel = $urandom_range(0, 16);
      endcase
    end

    // output held off while input keeps coming
    set_cfg(1, 2);
    gaps_on   = 1'b0;
    stall_req <= 1'b1;
    repeat (4) send_bases(10, 1'b1, 1'b0);
    gaps_on = 1'b1;

    // tail with no idling on either side
    set_cfg(2, 3);
    quiet   = 1'b1;
    gaps_on = 1'b0;
    repeat (4) send_bases($urandom_range(6, 14), 1'b1, $urandom_range(0, 1) == 1);
    drain();

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
